### sv/pfsd_pkg.sv
// Package for point_floor_sort_dedupe: field widths and the control/status
// structs exchanged between the controller and the datapath. No dependencies.
`default_nettype none

package pfsd_pkg;

	localparam int IN_W  = 24;
	localparam int OUT_W = 16;

	typedef struct packed {
		logic ins;   // insert the request point into the sorted row
		logic pop;   // move the head entry to the output register and shift
	} pfsd_cmd_t;

	typedef struct packed {
		logic cnt_one;   // exactly one entry left in the row
	} pfsd_sts_t;

endpackage

`default_nettype wire

### sv/pfsd_in_if.sv
// Input channel: one point request with valid/ready handshake.
// Depends on pfsd_pkg for field widths.
`default_nettype none

interface pfsd_in_if import pfsd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [IN_W-1:0]  x_in;
	logic signed [IN_W-1:0]  y_in;
	logic signed [IN_W-1:0]  z_in;
	logic                    last_in;

	modport source (output valid, output x_in, output y_in, output z_in, output last_in,
		input ready);
	modport sink (input valid, input x_in, input y_in, input z_in, input last_in,
		output ready);
endinterface

`default_nettype wire

### sv/pfsd_out_if.sv
// Output channel: one unique floored point per request, valid/ready handshake.
// Depends on pfsd_pkg for field widths.
`default_nettype none

interface pfsd_out_if import pfsd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] x_out;
	logic signed [OUT_W-1:0] y_out;
	logic signed [OUT_W-1:0] z_out;
	logic                    last_out;
	logic                    overflow;

	modport source (output valid, output x_out, output y_out, output z_out,
		output last_out, output overflow, input ready);
	modport sink (input valid, input x_out, input y_out, input z_out,
		input last_out, input overflow, output ready);
endinterface

`default_nettype wire

### sv/pfsd_ctrl.sv
// Controller for point_floor_sort_dedupe: accept/emit state machine and the
// output valid flag. Depends on pfsd_pkg.
`default_nettype none

module pfsd_ctrl import pfsd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_last,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	output pfsd_cmd_t      cmd,
	input  wire pfsd_sts_t sts
);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.ins   = in_valid && in_ready;
	assign cmd.pop   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (cmd.ins && in_last) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.pop) begin
						out_valid_q <= 1'b1;
						if (sts.cnt_one) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/pfsd_dp.sv
// Datapath for point_floor_sort_dedupe: coordinate floor/saturate, sorted
// register row with per-cell compares, output register. Depends on pfsd_pkg.
`default_nettype none

module pfsd_dp import pfsd_pkg::*; #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire pfsd_cmd_t               cmd,
	output pfsd_sts_t                    sts,
	input  wire logic signed [IN_W-1:0]  x_in,
	input  wire logic signed [IN_W-1:0]  y_in,
	input  wire logic signed [IN_W-1:0]  z_in,
	output logic signed [OUT_W-1:0]      x_out,
	output logic signed [OUT_W-1:0]      y_out,
	output logic signed [OUT_W-1:0]      z_out,
	output logic                         last_out,
	output logic                         overflow
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int SW = ((COORD_BITS > IN_W) ? COORD_BITS : IN_W) + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	function automatic coord_t floor_sat(input logic signed [IN_W-1:0] raw);
		logic signed [IN_W-1:0] fl;
		logic signed [SW-1:0]   fe;
		logic signed [SW-1:0]   hi;
		logic signed [SW-1:0]   lo;
		logic signed [SW-1:0]   r;
		fl = raw >>> FRAC_BITS;
		fe = {{(SW-IN_W){fl[IN_W-1]}}, fl};
		hi = {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
		lo = {{(SW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
		if (fe > hi) begin
			r = hi;
		end else if (fe < lo) begin
			r = lo;
		end else begin
			r = fe;
		end
		return r[COORD_BITS-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] to_out(input coord_t c);
		logic signed [SW-1:0] e;
		e = {{(SW-COORD_BITS){c[COORD_BITS-1]}}, c};
		return e[OUT_W-1:0];
	endfunction

	coord_t px, py, pz;
	coord_t sx_q [MAX_POINTS];
	coord_t sy_q [MAX_POINTS];
	coord_t sz_q [MAX_POINTS];
	coord_t nx   [MAX_POINTS];
	coord_t ny   [MAX_POINTS];
	coord_t nz   [MAX_POINTS];
	logic [MAX_POINTS-1:0] lt, eq;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          dup, full, do_ins;

	assign px = floor_sat(x_in);
	assign py = floor_sat(y_in);
	assign pz = floor_sat(z_in);

	always_comb begin
		for (int i = 0; i < MAX_POINTS; i++) begin
			lt[i] = (CW'(i) < cnt_q) && ((sx_q[i] < px) || (sx_q[i] == px &&
				((sy_q[i] < py) || (sy_q[i] == py && sz_q[i] < pz))));
			eq[i] = (CW'(i) < cnt_q) && sx_q[i] == px && sy_q[i] == py && sz_q[i] == pz;
		end
	end

	assign dup    = |eq;
	assign full   = (cnt_q == CW'(MAX_POINTS));
	assign do_ins = cmd.ins && !dup && !full;
	assign sts.cnt_one = (cnt_q == CW'(1));

	// insert: keep cells below the slot, write the slot, shift the rest up
	always_comb begin
		for (int i = 0; i < MAX_POINTS; i++) begin
			if (lt[i]) begin
				nx[i] = sx_q[i];
				ny[i] = sy_q[i];
				nz[i] = sz_q[i];
			end else if (i == 0 || lt[(i == 0) ? 0 : i-1]) begin
				nx[i] = px;
				ny[i] = py;
				nz[i] = pz;
			end else begin
				nx[i] = sx_q[(i == 0) ? 0 : i-1];
				ny[i] = sy_q[(i == 0) ? 0 : i-1];
				nz[i] = sz_q[(i == 0) ? 0 : i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_ins) begin
			for (int i = 0; i < MAX_POINTS; i++) begin
				sx_q[i] <= nx[i];
				sy_q[i] <= ny[i];
				sz_q[i] <= nz[i];
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < MAX_POINTS - 1; i++) begin
				sx_q[i] <= sx_q[i+1];
				sy_q[i] <= sy_q[i+1];
				sz_q[i] <= sz_q[i+1];
			end
		end
		if (cmd.pop) begin
			x_out    <= to_out(sx_q[0]);
			y_out    <= to_out(sy_q[0]);
			z_out    <= to_out(sz_q[0]);
			last_out <= sts.cnt_one;
			overflow <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.ins) begin
			if (do_ins) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!dup) begin
				ovf_q <= 1'b1;
			end
		end else if (cmd.pop) begin
			cnt_q <= cnt_q - CW'(1);
			if (sts.cnt_one) begin
				ovf_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### sv/point_floor_sort_dedupe.sv
// Top level of point_floor_sort_dedupe: controller plus sorted-row datapath.
// Depends on pfsd_pkg, pfsd_in_if, pfsd_out_if, pfsd_ctrl, pfsd_dp.
//
//   channel   dir  payload                                      role
//   in_ch     in   x_in, y_in, z_in (Q16.8), last_in            one point per request
//   out_ch    out  x_out, y_out, z_out, last_out, overflow      one unique point
//
// For each point request, floor, compare against every row cell and
// insert all happen at the accepting edge. After a request with last_in the
// row drains head first, one result per cycle through the output register
// while out_ch is ready; in_ch stalls during the drain. A stalled final result
// does not block the next set's requests. Reset clears count and overflow.
`default_nettype none

module point_floor_sort_dedupe import pfsd_pkg::*; #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pfsd_in_if.sink    in_ch,
	pfsd_out_if.source out_ch
);

	pfsd_cmd_t cmd;
	pfsd_sts_t sts;

	pfsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_last   (in_ch.last_in),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pfsd_dp #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.x_in     (in_ch.x_in),
		.y_in     (in_ch.y_in),
		.z_in     (in_ch.z_in),
		.x_out    (out_ch.x_out),
		.y_out    (out_ch.y_out),
		.z_out    (out_ch.z_out),
		.last_out (out_ch.last_out),
		.overflow (out_ch.overflow)
	);

endmodule

`default_nettype wire

### sv/pfsd_checker.sv
// Port-level checker for point_floor_sort_dedupe and its bind statement.
// Depends on pfsd_pkg for field widths.
`default_nettype none

module pfsd_checker import pfsd_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             in_last,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [OUT_W-1:0] x_out,
	input wire logic [OUT_W-1:0] y_out,
	input wire logic [OUT_W-1:0] z_out,
	input wire logic             last_out,
	input wire logic             overflow
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_out) && $stable(y_out) &&
			$stable(z_out) && $stable(last_out) && $stable(overflow))
		else $error("output request changed while stalled");

	a_last_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input taken right after a last request");

	a_drain_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_out |-> !in_ready)
		else $error("input taken in the middle of a drain");

	a_drain_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_out |=> out_valid && overflow == $past(overflow))
		else $error("drain gap or overflow flag changed within a set");

endmodule

bind point_floor_sort_dedupe pfsd_checker u_pfsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_last   (in_ch.last_in),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.x_out     (out_ch.x_out),
	.y_out     (out_ch.y_out),
	.z_out     (out_ch.z_out),
	.last_out  (out_ch.last_out),
	.overflow  (out_ch.overflow)
);

`default_nettype wire

### tb/tb_point_floor_sort_dedupe.sv
// Self-checking testbench for point_floor_sort_dedupe: drives point requests and
// predicts the sorted, deduplicated and floored output sets with a queue model.
// Depends on pfsd_pkg, pfsd_in_if, pfsd_out_if and the point_floor_sort_dedupe RTL.
`timescale 1ns / 100ps

module tb_point_floor_sort_dedupe;
	import pfsd_pkg::*;

	localparam int MAX_PTS   = 64;
	localparam int CRD_BITS  = 16;
	localparam int FRC_BITS  = 8;
	localparam int CRD_MAX   = (1 << (CRD_BITS - 1)) - 1;
	localparam int CRD_MIN   = -(1 << (CRD_BITS - 1));
	localparam int RAND_REQS = 320;

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] z;
	} point_t;

	typedef struct packed {
		point_t p;
		logic   last;
		logic   ovf;
	} result_t;

	logic clk;
	logic arst_n;
	bit   no_idle;
	int   err_cnt;
	int   req_cnt;

	point_t  sorted_row[$];
	bit      row_dropped;
	result_t expected_pts[$];

	pfsd_in_if  in_ch();
	pfsd_out_if out_ch();

	point_floor_sort_dedupe #(
		.MAX_POINTS(MAX_PTS),
		.COORD_BITS(CRD_BITS),
		.FRAC_BITS(FRC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic signed [OUT_W-1:0] floor_coord(logic signed [IN_W-1:0] raw);
		logic signed [IN_W-1:0] sh;
		sh = raw >>> FRC_BITS;
		if (sh > CRD_MAX)
			sh = CRD_MAX;
		if (sh < CRD_MIN)
			sh = CRD_MIN;
		return sh[OUT_W-1:0];
	endfunction

	function automatic bit pt_less(point_t a, point_t b);
		if (a.x != b.x)
			return a.x < b.x;
		if (a.y != b.y)
			return a.y < b.y;
		return a.z < b.z;
	endfunction

	// Sorted insert with dedupe; a last request flushes the row into expected_pts.
	function automatic void insert_point(logic [IN_W-1:0] xr, logic [IN_W-1:0] yr,
			logic [IN_W-1:0] zr, bit last);
		point_t  p;
		result_t r;
		int      pos;
		bit      dup;
		p.x = floor_coord(xr);
		p.y = floor_coord(yr);
		p.z = floor_coord(zr);
		pos = 0;
		dup = 1'b0;
		while (pos < sorted_row.size()) begin
			if (sorted_row[pos] == p) begin
				dup = 1'b1;
				break;
			end
			if (pt_less(p, sorted_row[pos]))
				break;
			pos++;
		end
		if (!dup) begin
			if (sorted_row.size() >= MAX_PTS)
				row_dropped = 1'b1;
			else
				sorted_row.insert(pos, p);
		end
		if (last) begin
			foreach (sorted_row[i]) begin
				r.p    = sorted_row[i];
				r.last = (i == sorted_row.size() - 1);
				r.ovf  = row_dropped;
				expected_pts.push_back(r);
			end
			sorted_row.delete();
			row_dropped = 1'b0;
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_point(logic [IN_W-1:0] xr, logic [IN_W-1:0] yr,
			logic [IN_W-1:0] zr, bit last);
		while (!no_idle && $urandom_range(99) < 6) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.x_in    <= xr;
		in_ch.y_in    <= yr;
		in_ch.z_in    <= zr;
		in_ch.last_in <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		insert_point(xr, yr, zr, last);
		req_cnt++;
		@(negedge clk);
	endtask

	function automatic logic [IN_W-1:0] rand_coord(bit narrow);
		logic [15:0] whole;
		if (!narrow)
			return IN_W'($urandom);
		whole = 16'($urandom_range(6)) - 16'd3;
		return {whole, 8'($urandom)};
	endfunction

	task automatic test_single_point();
		send_point(24'h7FFFFF, 24'h800000, 24'h000000, 1'b1);
	endtask

	// Extremes, negative floors, fractional duplicates, tie-breaks on y and z,
	// and a last request that is itself a duplicate.
	task automatic test_order_dedupe();
		send_point(24'h000000, 24'h000000, 24'h000000, 1'b0);
		send_point(24'h0000FF, 24'h000080, 24'h000001, 1'b0);
		send_point(24'hFFFFFF, 24'h000000, 24'h000000, 1'b0);
		send_point(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
		send_point(24'h7FFFFF, 24'h800000, 24'h800000, 1'b0);
		send_point(24'h000100, 24'h000000, 24'h000000, 1'b0);
		send_point(24'h000000, 24'h000100, 24'h000000, 1'b0);
		send_point(24'h000000, 24'hFFFF00, 24'h000000, 1'b0);
		send_point(24'h000000, 24'h000000, 24'hFFFFFF, 1'b0);
		send_point(24'h000000, 24'h000000, 24'h000100, 1'b0);
		send_point(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
		send_point(24'hFFFFFF, 24'h0000FF, 24'h0000AA, 1'b1);
	endtask

	// Short sets back to back: the next set must not wait on a stalled final result.
	task automatic test_back_to_back();
		send_point(24'h123456, 24'hABCDEF, 24'h555555, 1'b1);
		send_point(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b1);
		send_point(24'h000200, 24'h000000, 24'h000000, 1'b0);
		send_point(24'h000100, 24'h000000, 24'h000000, 1'b1);
	endtask

	// Full row: duplicates arriving when full must not flag overflow.
	task automatic test_full_dups();
		for (int i = 0; i < MAX_PTS; i++)
			send_point({16'(MAX_PTS - 1 - i), 8'($urandom)}, 24'h000000,
				24'h000000, 1'b0);
		send_point(24'h000000, 24'h000000, 24'h000000, 1'b0);
		send_point({16'(MAX_PTS - 1), 8'hFF}, 24'h000000, 24'h000000, 1'b1);
	endtask

	task automatic test_overflow();
		for (int i = 0; i < MAX_PTS; i++)
			send_point({16'(i), 8'h00}, 24'h000000, 24'h000000, 1'b0);
		send_point(24'h800000, 24'h000000, 24'h000000, 1'b0);
		send_point({16'(MAX_PTS), 8'h00}, 24'h000000, 24'h000000, 1'b1);
	endtask

	task automatic test_random();
		int  start_cnt;
		int  set_len;
		int  pick;
		bit  narrow;
		start_cnt = req_cnt;
		while (req_cnt - start_cnt < RAND_REQS) begin
			pick = $urandom_range(99);
			if (pick < 85)
				set_len = $urandom_range(24, 1);
			else if (pick < 95)
				set_len = $urandom_range(MAX_PTS, 25);
			else
				set_len = $urandom_range(MAX_PTS + 16, MAX_PTS + 1);
			narrow = ($urandom_range(1) == 0);
			no_idle = (req_cnt - start_cnt >= 200) && (req_cnt - start_cnt < 300);
			for (int i = 0; i < set_len; i++)
				send_point(rand_coord(narrow), rand_coord(narrow), rand_coord(narrow),
					i == set_len - 1);
		end
		no_idle = 1'b0;
	endtask

	always @(negedge clk)
		out_ch.ready <= no_idle || ($urandom_range(99) >= 6);

	always @(posedge clk) begin
		result_t got;
		result_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.p.x  = out_ch.x_out;
			got.p.y  = out_ch.y_out;
			got.p.z  = out_ch.z_out;
			got.last = out_ch.last_out;
			got.ovf  = out_ch.overflow;
			if (expected_pts.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("%0t: unexpected result x=%0d y=%0d z=%0d last=%0b ovf=%0b",
						$realtime, got.p.x, got.p.y, got.p.z, got.last, got.ovf);
			end else begin
				exp_r = expected_pts.pop_front();
				if (got !== exp_r) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: mismatch exp x=%0d y=%0d z=%0d last=%0b ovf=%0b, %s",
							$realtime, exp_r.p.x, exp_r.p.y, exp_r.p.z, exp_r.last,
							exp_r.ovf, $sformatf("got x=%0d y=%0d z=%0d last=%0b ovf=%0b",
							got.p.x, got.p.y, got.p.z, got.last, got.ovf));
				end
			end
		end
	end

	initial begin
		#1000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		no_idle       = 1'b0;
		err_cnt       = 0;
		req_cnt       = 0;
		row_dropped   = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.x_in    = '0;
		in_ch.y_in    = '0;
		in_ch.z_in    = '0;
		in_ch.last_in = 1'b0;
		out_ch.ready  = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_single_point();
		test_order_dedupe();
		test_back_to_back();
		test_full_dups();
		test_overflow();
		test_random();

		in_ch.valid <= 1'b0;
		while (expected_pts.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
